[hdl/chc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package chc_pkg;

   localparam int BIN_COUNT    = 256;
   localparam int MAX_CHANNELS = 3;
   localparam int COUNT_BITS   = 32;

   localparam int STORE_DEPTH = MAX_CHANNELS * BIN_COUNT;
   localparam int BIN_BITS    = $clog2(BIN_COUNT);
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

   // fixed widths of the transaction fields
   localparam int CH_BITS    = 2;
   localparam int LEVEL_BITS = 8;
   localparam int IDX_BITS   = 8;
   localparam int OUT_BITS   = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_READ       = 1'b1;

   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [BIN_BITS-1:0]   bin_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // control carried from the issue stage to the update stage
   typedef struct packed {
      logic     valid;
      logic     is_read;
      logic     err;
      logic     restart;
      logic     last;
      bin_type  bin;
      addr_type addr;
   } stage_type;

endpackage

`default_nettype wire

[hdl/chc_bin_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module chc_bin_ram
   import chc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      rd_en,
   input  wire addr_type  rd_addr,
   output count_type      rd_data,
   input  wire logic      wr_en,
   input  wire addr_type  wr_addr,
   input  wire count_type wr_data
);

   count_type mem [STORE_DEPTH];
   count_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read returns the old contents on a same-cycle write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/chc_issue.sv]
`timescale 1ns / 1ps
`default_nettype none

module chc_issue
   import chc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  operation,
   input  wire logic [CH_BITS-1:0]    channel,
   input  wire logic [LEVEL_BITS-1:0] intensity,
   input  wire logic [CH_BITS-1:0]    channels_in_use,
   output logic                       busy,
   output logic                       rd_en,
   output addr_type                   rd_addr,
   output logic                       clr_en,
   output addr_type                   clr_addr,
   output stage_type                  stage
);

   logic               clearing_ff, clearing_in;
   addr_type           clr_cnt_ff, clr_cnt_in;
   logic [CH_BITS-1:0] rd_chan_ff, rd_chan_in;
   bin_type            next_bin_ff, next_bin_in;
   logic               stage_valid_ff, stage_valid_in;
   stage_type          stage_ff, stage_in;

   logic    accept;
   logic    active;
   logic    change;
   logic    in_range;
   bin_type bin;
   logic    last;

   assign busy   = clearing_ff;
   assign accept = start && !clearing_ff;

   assign active   = (int'(channel) < int'(channels_in_use)) && (int'(channel) < MAX_CHANNELS);
   assign in_range = int'(intensity) < BIN_COUNT;
   assign change   = channel != rd_chan_ff;
   assign bin      = change ? '0 : next_bin_ff;
   assign last     = int'(bin) == BIN_COUNT - 1;

   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (int'(clr_cnt_ff) == STORE_DEPTH - 1) begin
            clearing_in = 1'b0;
         end
      end
   end

   assign clr_en   = clearing_ff;
   assign clr_addr = clr_cnt_ff;

   always_comb begin
      rd_chan_in     = rd_chan_ff;
      next_bin_in    = next_bin_ff;
      stage_valid_in = 1'b0;
      stage_in       = stage_ff;
      rd_en          = 1'b0;
      rd_addr        = ADDR_BITS'(int'(channel) * BIN_COUNT + int'(bin));
      if (accept) begin
         stage_in.is_read = operation;
         stage_in.err     = !active;
         stage_in.restart = change;
         stage_in.last    = last;
         stage_in.bin     = bin;
         unique case (operation)
            OP_ACCUMULATE: begin
               rd_addr        = ADDR_BITS'(int'(channel) * BIN_COUNT + int'(intensity));
               stage_valid_in = active && in_range;
               rd_en          = active && in_range;
            end
            OP_READ: begin
               stage_valid_in = 1'b1;
               rd_en          = active;
               rd_chan_in     = channel;
               if (!active || last) begin
                  next_bin_in = '0;
               end else begin
                  next_bin_in = bin + 1'b1;
               end
            end
            default: begin
               stage_valid_in = 1'b0;
            end
         endcase
         stage_in.addr = rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff    <= 1'b1;
         clr_cnt_ff     <= '0;
         rd_chan_ff     <= '0;
         next_bin_ff    <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         clearing_ff    <= clearing_in;
         clr_cnt_ff     <= clr_cnt_in;
         rd_chan_ff     <= rd_chan_in;
         next_bin_ff    <= next_bin_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   always_comb begin
      stage       = stage_ff;
      stage.valid = stage_valid_ff;
   end

endmodule

`default_nettype wire

[hdl/chc_update.sv]
`timescale 1ns / 1ps
`default_nettype none

module chc_update
   import chc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire stage_type    stage,
   input  wire count_type    rd_data,
   output logic              wr_en,
   output addr_type          wr_addr,
   output count_type         wr_data,
   output logic              rsp_strobe,
   output logic [IDX_BITS-1:0] rsp_bin_index,
   output logic [OUT_BITS-1:0] rsp_occurrence_count,
   output logic [OUT_BITS-1:0] rsp_cumulative_count,
   output logic              rsp_final_bin,
   output logic              rsp_channel_error
);

   logic      fwd_valid_ff, fwd_valid_in;
   addr_type  fwd_addr_ff;
   count_type fwd_data_ff;
   count_type sum_ff, sum_in;

   logic                strobe_ff, strobe_in;
   logic [IDX_BITS-1:0] index_ff, index_in;
   logic [OUT_BITS-1:0] occ_ff, occ_in;
   logic [OUT_BITS-1:0] cum_ff, cum_in;
   logic                final_ff, final_in;
   logic                err_ff, err_in;

   count_type         data;
   count_type         base;
   logic [COUNT_BITS:0] total;
   count_type         new_sum;

   // take the value written last cycle; the memory still shows the old one
   assign data = (fwd_valid_ff && fwd_addr_ff == stage.addr) ? fwd_data_ff : rd_data;

   assign wr_en   = stage.valid && !stage.is_read;
   assign wr_addr = stage.addr;
   assign wr_data = (data == COUNT_MAX) ? data : data + 1'b1;
   assign fwd_valid_in = wr_en;

   assign base    = stage.restart ? '0 : sum_ff;
   assign total   = {1'b0, base} + {1'b0, data};
   assign new_sum = total[COUNT_BITS] ? COUNT_MAX : total[COUNT_BITS-1:0];

   always_comb begin
      sum_in    = sum_ff;
      strobe_in = stage.valid && stage.is_read;
      index_in  = IDX_BITS'(stage.bin);
      occ_in    = OUT_BITS'(data);
      cum_in    = OUT_BITS'(new_sum);
      final_in  = stage.last;
      err_in    = stage.err;
      if (stage.err) begin
         index_in = '0;
         occ_in   = '0;
         cum_in   = '0;
         final_in = 1'b0;
      end
      if (strobe_in) begin
         if (stage.err || stage.last) begin
            sum_in = '0;
         end else begin
            sum_in = new_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         sum_ff       <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
         sum_ff       <= sum_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
      index_ff    <= index_in;
      occ_ff      <= occ_in;
      cum_ff      <= cum_in;
      final_ff    <= final_in;
      err_ff      <= err_in;
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_bin_index        = index_ff;
   assign rsp_occurrence_count = occ_ff;
   assign rsp_cumulative_count = cum_ff;
   assign rsp_final_bin        = final_ff;
   assign rsp_channel_error    = err_ff;

endmodule

`default_nettype wire

[hdl/channel_histogram_cumulative_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Carries
// request   in         start / busy           operation, channel, intensity
// response  out        rsp_strobe (1 cycle)   bin, count, cumulative, flags
// csr       in         csr_valid / csr_ready  channels_in_use
//
// One transaction is taken per clock while busy is low; a read's result
// is registered at the issue stage and again at the update outputs. The
// rate is set by the bin memory's read-modify-write loop, which forwards
// the last write to keep one per cycle. After reset a clearing pass zeroes
// the 768-entry bin memory, one entry a cycle, and holds busy high until
// every entry is cleared. Results cannot be stalled by the receiver.

module channel_histogram_cumulative_top
   import chc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_operation,
   input  wire logic [CH_BITS-1:0]    req_channel,
   input  wire logic [LEVEL_BITS-1:0] req_intensity,
   output logic                       rsp_strobe,
   output logic [IDX_BITS-1:0]        rsp_bin_index,
   output logic [OUT_BITS-1:0]        rsp_occurrence_count,
   output logic [OUT_BITS-1:0]        rsp_cumulative_count,
   output logic                       rsp_final_bin,
   output logic                       rsp_channel_error,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CH_BITS-1:0]    csr_data
);

   logic [CH_BITS-1:0] chan_use_ff, chan_use_in;

   logic      rd_en;
   addr_type  rd_addr;
   count_type rd_data;
   logic      clr_en;
   addr_type  clr_addr;
   logic      upd_wr_en;
   addr_type  upd_wr_addr;
   count_type upd_wr_data;
   logic      ram_wr_en;
   addr_type  ram_wr_addr;
   count_type ram_wr_data;
   stage_type stage;

   assign csr_ready   = 1'b1;
   assign chan_use_in = (csr_valid && csr_ready) ? csr_data : chan_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_use_ff <= CH_BITS'(1);
      end else begin
         chan_use_ff <= chan_use_in;
      end
   end

   chc_issue u_issue (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .operation       (req_operation),
      .channel         (req_channel),
      .intensity       (req_intensity),
      .channels_in_use (chan_use_ff),
      .busy            (busy),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .clr_en          (clr_en),
      .clr_addr        (clr_addr),
      .stage           (stage)
   );

   // clearing pass owns the write port while busy
   assign ram_wr_en   = clr_en || upd_wr_en;
   assign ram_wr_addr = clr_en ? clr_addr : upd_wr_addr;
   assign ram_wr_data = clr_en ? '0 : upd_wr_data;

   chc_bin_ram u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   chc_update u_update (
      .clock                (clock),
      .reset                (reset),
      .stage                (stage),
      .rd_data              (rd_data),
      .wr_en                (upd_wr_en),
      .wr_addr              (upd_wr_addr),
      .wr_data              (upd_wr_data),
      .rsp_strobe           (rsp_strobe),
      .rsp_bin_index        (rsp_bin_index),
      .rsp_occurrence_count (rsp_occurrence_count),
      .rsp_cumulative_count (rsp_cumulative_count),
      .rsp_final_bin        (rsp_final_bin),
      .rsp_channel_error    (rsp_channel_error)
   );

endmodule

`default_nettype wire

[hdl/chc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module chc_checker
   import chc_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                req_operation,
   input wire logic                rsp_strobe,
   input wire logic [IDX_BITS-1:0] rsp_bin_index,
   input wire logic [OUT_BITS-1:0] rsp_occurrence_count,
   input wire logic [OUT_BITS-1:0] rsp_cumulative_count,
   input wire logic                rsp_final_bin,
   input wire logic                rsp_channel_error
);

   // the clearing pass must hold off transactions right after reset
   assert property (@(posedge clock) reset |=> busy)
      else $error("busy not raised after reset");

   // every result comes from an accepted read
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_operation == OP_READ, 2))
      else $error("result without a matching read");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_channel_error) |->
         (rsp_bin_index == '0 && rsp_occurrence_count == '0 &&
          rsp_cumulative_count == '0 && !rsp_final_bin))
      else $error("error result carries data");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_channel_error) |-> rsp_cumulative_count >= rsp_occurrence_count)
      else $error("cumulative count below bin count");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_final_bin) |-> rsp_bin_index == IDX_BITS'(BIN_COUNT - 1))
      else $error("final flag on wrong bin");

endmodule

bind channel_histogram_cumulative_top chc_checker u_chc_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_operation        (req_operation),
   .rsp_strobe           (rsp_strobe),
   .rsp_bin_index        (rsp_bin_index),
   .rsp_occurrence_count (rsp_occurrence_count),
   .rsp_cumulative_count (rsp_cumulative_count),
   .rsp_final_bin        (rsp_final_bin),
   .rsp_channel_error    (rsp_channel_error)
);

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
   import chc_pkg::*;

   typedef struct {
      logic                  op;
      logic [CH_BITS-1:0]    ch;
      logic [LEVEL_BITS-1:0] level;
      int unsigned           gap;
      bit                    drain;
   } hist_cmd_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] bin;
      logic [OUT_BITS-1:0] occ;
      logic [OUT_BITS-1:0] cum;
      logic                last;
      logic                err;
   } bin_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic req_operation = OP_ACCUMULATE;
   logic [CH_BITS-1:0] req_channel = '0;
   logic [LEVEL_BITS-1:0] req_intensity = '0;
   logic csr_valid = 1'b0;
   logic [CH_BITS-1:0] csr_data = '0;

   wire logic                busy;
   wire logic                rsp_strobe;
   wire logic [IDX_BITS-1:0] rsp_bin_index;
   wire logic [OUT_BITS-1:0] rsp_occurrence_count;
   wire logic [OUT_BITS-1:0] rsp_cumulative_count;
   wire logic                rsp_final_bin;
   wire logic                rsp_channel_error;
   wire logic                csr_ready;

   channel_histogram_cumulative_top dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_channel          (req_channel),
      .req_intensity        (req_intensity),
      .rsp_strobe           (rsp_strobe),
      .rsp_bin_index        (rsp_bin_index),
      .rsp_occurrence_count (rsp_occurrence_count),
      .rsp_cumulative_count (rsp_cumulative_count),
      .rsp_final_bin        (rsp_final_bin),
      .rsp_channel_error    (rsp_channel_error),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   count_type          hist_store [STORE_DEPTH];
   logic [CH_BITS-1:0] walk_channel = '0;
   int unsigned        walk_bin = 0;
   count_type          walk_sum = '0;
   logic [CH_BITS-1:0] chan_limit = 2'd1;

   hist_cmd_type   histogram_cmds [$];
   bin_report_type expected_bins [$];

   int unsigned queued_count = 0;
   int unsigned accepted_count = 0;
   int unsigned report_count = 0;
   int unsigned final_count = 0;
   int unsigned error_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned wait_left = 0;
   bit          req_taken = 1'b0;
   bit          csr_done = 1'b0;
   bit          no_idle = 1'b0;

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) hist_store[i] = '0;
   end

   task automatic flag_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic track_histogram(input logic op, input logic [CH_BITS-1:0] ch,
                                  input logic [LEVEL_BITS-1:0] level);
      bin_report_type rep;
      int unsigned    slot;
      count_type      cnt;
      logic           active;
      active = (ch < chan_limit) && (ch < MAX_CHANNELS);
      if (op == OP_ACCUMULATE) begin
         if (active && level < BIN_COUNT) begin
            slot = ch * BIN_COUNT + level;
            if (hist_store[slot] != COUNT_MAX) hist_store[slot] = hist_store[slot] + 1'b1;
         end
      end else begin
         if (ch != walk_channel) begin
            walk_channel = ch;
            walk_bin = 0;
            walk_sum = '0;
         end
         rep = '0;
         if (!active) begin
            walk_bin = 0;
            walk_sum = '0;
            rep.err = 1'b1;
         end else begin
            cnt = hist_store[ch * BIN_COUNT + walk_bin];
            if (COUNT_MAX - walk_sum < cnt) walk_sum = COUNT_MAX;
            else walk_sum = walk_sum + cnt;
            rep.bin = IDX_BITS'(walk_bin);
            rep.occ = OUT_BITS'(cnt);
            rep.cum = OUT_BITS'(walk_sum);
            rep.last = (walk_bin == BIN_COUNT - 1);
            if (rep.last) begin
               walk_bin = 0;
               walk_sum = '0;
            end else begin
               walk_bin++;
            end
         end
         expected_bins.push_back(rep);
      end
   endtask

   // monitor: sample at the rising edge
   always @(posedge clock) begin : monitor
      bin_report_type exp_rep;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_strobe) begin
            report_count++;
            if (expected_bins.size() == 0) begin
               flag_mismatch($sformatf("result with nothing expected, bin %0d", rsp_bin_index));
            end else begin
               exp_rep = expected_bins.pop_front();
               if (rsp_bin_index !== exp_rep.bin)
                  flag_mismatch($sformatf("bin_index %0d, want %0d", rsp_bin_index, exp_rep.bin));
               if (rsp_occurrence_count !== exp_rep.occ)
                  flag_mismatch($sformatf("occurrence_count %0d, want %0d (bin %0d)",
                                          rsp_occurrence_count, exp_rep.occ, exp_rep.bin));
               if (rsp_cumulative_count !== exp_rep.cum)
                  flag_mismatch($sformatf("cumulative_count %0d, want %0d (bin %0d)",
                                          rsp_cumulative_count, exp_rep.cum, exp_rep.bin));
               if (rsp_final_bin !== exp_rep.last)
                  flag_mismatch($sformatf("final_bin %b, want %b (bin %0d)",
                                          rsp_final_bin, exp_rep.last, exp_rep.bin));
               if (rsp_channel_error !== exp_rep.err)
                  flag_mismatch($sformatf("channel_error %b, want %b",
                                          rsp_channel_error, exp_rep.err));
               if (exp_rep.last) final_count++;
               if (exp_rep.err) error_count++;
            end
         end
         req_taken = start && !busy;
         if (req_taken) begin
            accepted_count++;
            track_histogram(req_operation, req_channel, req_intensity);
         end
         if (csr_valid && csr_ready) begin
            chan_limit = csr_data;
            csr_done = 1'b1;
         end
      end
   end

   // driver: change inputs at the falling edge
   always @(negedge clock) begin : driver
      hist_cmd_type cmd;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         // hold the transaction until it is taken
      end else if (wait_left > 0) begin
         wait_left--;
         start <= 1'b0;
      end else if (histogram_cmds.size() > 0 &&
                   !(histogram_cmds[0].drain && expected_bins.size() != 0)) begin
         cmd = histogram_cmds.pop_front();
         start <= 1'b1;
         req_operation <= cmd.op;
         req_channel <= cmd.ch;
         req_intensity <= cmd.level;
         wait_left = cmd.gap;
      end else begin
         start <= 1'b0;
      end
   end

   function automatic void queue_cmd(input logic op, input logic [CH_BITS-1:0] ch,
                                     input logic [LEVEL_BITS-1:0] level);
      hist_cmd_type cmd;
      if ($urandom_range(49, 0) == 0) no_idle = !no_idle;
      cmd.op = op;
      cmd.ch = ch;
      cmd.level = level;
      cmd.gap = no_idle ? 0 : $urandom_range(14, 0);
      cmd.drain = ($urandom_range(59, 0) == 0);
      histogram_cmds.push_back(cmd);
      queued_count++;
   endfunction

   function automatic logic [LEVEL_BITS-1:0] pick_level(input logic [LEVEL_BITS-1:0] hot);
      int unsigned pick;
      pick = $urandom_range(9, 0);
      if (pick < 3) return hot;
      if (pick == 3) return ($urandom_range(1, 0) != 0) ? 8'd0 : 8'd255;
      return LEVEL_BITS'($urandom_range(255, 0));
   endfunction

   // mostly accumulate bursts and bin walks, the rest noise
   function automatic void queue_random(input int unsigned budget);
      int unsigned          issued;
      int unsigned          len;
      int unsigned          pick;
      logic [CH_BITS-1:0]   ch;
      logic [LEVEL_BITS-1:0] hot;
      logic [LEVEL_BITS-1:0] level;
      issued = 0;
      while (issued < budget) begin
         pick = $urandom_range(99, 0);
         hot = LEVEL_BITS'($urandom_range(255, 0));
         if (pick < 45) begin
            len = $urandom_range(30, 4);
            if (len > budget - issued) len = budget - issued;
            for (int i = 0; i < len; i++) begin
               ch = ($urandom_range(9, 0) < 8) ? CH_BITS'($urandom_range(2, 0))
                                               : CH_BITS'($urandom_range(3, 0));
               level = pick_level(hot);
               queue_cmd(OP_ACCUMULATE, ch, level);
            end
            issued += len;
         end else if (pick < 85) begin
            ch = ($urandom_range(7, 0) == 0) ? 2'd3 : CH_BITS'($urandom_range(2, 0));
            len = ($urandom_range(3, 0) == 0) ? BIN_COUNT : $urandom_range(40, 1);
            if (len > budget - issued) len = budget - issued;
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(11, 0) == 0) begin
                  queue_cmd(OP_ACCUMULATE, ch, pick_level(hot));
                  issued++;
               end
               queue_cmd(OP_READ, ch, LEVEL_BITS'($urandom_range(255, 0)));
            end
            issued += len;
         end else begin
            queue_cmd(($urandom_range(1, 0) != 0) ? OP_READ : OP_ACCUMULATE,
                      CH_BITS'($urandom_range(3, 0)), LEVEL_BITS'($urandom_range(255, 0)));
            issued++;
         end
      end
   endfunction

   task automatic wait_all_done();
      while (accepted_count != queued_count || expected_bins.size() != 0) @(negedge clock);
      // let trailing accumulates leave the pipeline
      repeat (6) @(negedge clock);
   endtask

   task automatic write_chan_limit(input logic [CH_BITS-1:0] value);
      csr_done = 1'b0;
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(negedge clock); while (!csr_done);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CH_BITS-1:0] limits [6];
      int unsigned        budgets [6];
      limits = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1};
      budgets = '{280, 450, 350, 150, 450, 200};
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, dropped samples, readout restarts, error reads
      queue_cmd(OP_ACCUMULATE, 2'd0, 8'd0);
      queue_cmd(OP_ACCUMULATE, 2'd0, 8'd255);
      queue_cmd(OP_ACCUMULATE, 2'd0, 8'd255);
      queue_cmd(OP_ACCUMULATE, 2'd1, 8'd10);
      queue_cmd(OP_ACCUMULATE, 2'd3, 8'd255);
      queue_cmd(OP_ACCUMULATE, 2'd2, 8'd7);
      queue_cmd(OP_READ, 2'd0, 8'd0);
      queue_cmd(OP_ACCUMULATE, 2'd0, 8'd1);
      queue_cmd(OP_READ, 2'd0, 8'd255);
      queue_cmd(OP_READ, 2'd1, 8'd0);
      queue_cmd(OP_READ, 2'd0, 8'd0);
      queue_cmd(OP_READ, 2'd3, 8'd0);
      queue_cmd(OP_READ, 2'd3, 8'd170);
      queue_cmd(OP_READ, 2'd0, 8'd85);
      queue_cmd(OP_READ, 2'd0, 8'd0);

      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            write_chan_limit(limits[p]);
            @(posedge clock);
         end
         queue_random(budgets[p]);
         wait_all_done();
      end

      $display("Covered %0d transactions, %0d results checked over channel limits 1,3,2,0,3,1",
               accepted_count, report_count);
      $display("Complete bin walks: %0d, reads of unused channels: %0d",
               final_count, error_count);
      if (mismatch_count == 0 && expected_bins.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("Timeout: %0d results still expected", expected_bins.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

[files.f]
hdl/chc_pkg.sv
hdl/chc_bin_ram.sv
hdl/chc_issue.sv
hdl/chc_update.sv
hdl/channel_histogram_cumulative_top.sv
hdl/chc_checker.sv
bench/tb.sv
